>>> rtl/core/pcmag_pkg.sv
// Shared types and register codes of the two-channel PCM address generator.
package pcmag_pkg;

  localparam logic [3:0] REG_RELOAD_LO_A = 4'h0;
  localparam logic [3:0] REG_RELOAD_HI_A = 4'h1;
  localparam logic [3:0] REG_START_0_A   = 4'h2;
  localparam logic [3:0] REG_START_1_A   = 4'h3;
  localparam logic [3:0] REG_START_2_A   = 4'h4;
  localparam logic [3:0] REG_TRIG_A      = 4'h5;
  localparam logic [3:0] REG_RELOAD_LO_B = 4'h6;
  localparam logic [3:0] REG_RELOAD_HI_B = 4'h7;
  localparam logic [3:0] REG_START_0_B   = 4'h8;
  localparam logic [3:0] REG_START_1_B   = 4'h9;
  localparam logic [3:0] REG_START_2_B   = 4'hA;
  localparam logic [3:0] REG_TRIG_B      = 4'hB;
  localparam logic [3:0] REG_LEVEL       = 4'hC;
  localparam logic [3:0] REG_LOOP        = 4'hD;

  localparam logic [3:0] NIBBLE_TOP      = 4'hF;
  localparam logic [3:0] SEVEN_RESTART   = 4'h9;

  typedef struct packed {
    logic       clk_level;
    logic       reset_active;
    logic       write_strobe_n;
    logic [3:0] bus_address;
    logic [7:0] bus_data;
    logic [7:0] rom_byte;
  } item_t;

  typedef struct packed {
    logic [16:0] rom_address;
    logic [6:0]  sample_a;
    logic [6:0]  sample_b;
    logic        level_strobe_n;
    logic        clock_e_n;
    logic        clock_q_n;
    logic        aux_clock_out;
  } result_t;

  typedef struct packed {
    logic [11:0] reload;
    logic [1:0]  mode;
    logic [16:0] start;
    logic        loop_en;
  } chan_cfg_t;

  typedef struct packed {
    logic level_n;
    logic trig_a;
    logic trig_b;
    logic pre_a;
    logic pre_b;
  } bus_ctl_t;

  typedef struct packed {
    logic e;
    logic q;
    logic d4;
    logic e_rise;
    logic d4_rise;
    logic d4_fall;
    logic aux;
  } clk_ctl_t;

endpackage

>>> rtl/core/pcmag_bus.sv
// Bus interface: write-select edge detect, register decode and channel register file.
module pcmag_bus (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 write_strobe_n,
  input  logic [3:0]           bus_address,
  input  logic [7:0]           bus_data,
  output pcmag_pkg::bus_ctl_t  ctl,
  output pcmag_pkg::chan_cfg_t cfg_a,
  output pcmag_pkg::chan_cfg_t cfg_b
);

  logic                 p_ws;
  pcmag_pkg::chan_cfg_t reg_a;
  pcmag_pkg::chan_cfg_t reg_b;
  logic [3:0]           a;
  logic                 wfall;

  assign a     = {bus_address[3:1], ~bus_address[0]};
  assign wfall = p_ws && !write_strobe_n;

  always_comb begin
    ctl.level_n = !(!write_strobe_n && a == pcmag_pkg::REG_LEVEL);
    ctl.trig_a  = wfall && a == pcmag_pkg::REG_TRIG_A;
    ctl.trig_b  = wfall && a == pcmag_pkg::REG_TRIG_B;
    ctl.pre_a   = !write_strobe_n &&
                  (a == pcmag_pkg::REG_RELOAD_LO_A || a == pcmag_pkg::REG_RELOAD_HI_A);
    ctl.pre_b   = !write_strobe_n &&
                  (a == pcmag_pkg::REG_RELOAD_LO_B || a == pcmag_pkg::REG_RELOAD_HI_B);
  end

  always_comb begin
    cfg_a = reg_a;
    cfg_b = reg_b;
    if (wfall) begin
      unique case (a)
        pcmag_pkg::REG_RELOAD_LO_A: cfg_a.reload[7:0] = bus_data;
        pcmag_pkg::REG_RELOAD_HI_A: begin
          cfg_a.reload[11:8] = bus_data[3:0];
          cfg_a.mode         = bus_data[5:4];
        end
        pcmag_pkg::REG_START_0_A:   cfg_a.start[7:0]  = bus_data;
        pcmag_pkg::REG_START_1_A:   cfg_a.start[15:8] = bus_data;
        pcmag_pkg::REG_START_2_A:   cfg_a.start[16]   = bus_data[0];
        pcmag_pkg::REG_RELOAD_LO_B: cfg_b.reload[7:0] = bus_data;
        pcmag_pkg::REG_RELOAD_HI_B: begin
          cfg_b.reload[11:8] = bus_data[3:0];
          cfg_b.mode         = bus_data[5:4];
        end
        pcmag_pkg::REG_START_0_B:   cfg_b.start[7:0]  = bus_data;
        pcmag_pkg::REG_START_1_B:   cfg_b.start[15:8] = bus_data;
        pcmag_pkg::REG_START_2_B:   cfg_b.start[16]   = bus_data[0];
        pcmag_pkg::REG_LOOP: begin
          cfg_a.loop_en = bus_data[0];
          cfg_b.loop_en = bus_data[1];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_ws  <= 1'b0;
      reg_a <= '0;
      reg_b <= '0;
    end else if (step) begin
      p_ws  <= write_strobe_n;
      reg_a <= cfg_a;
      reg_b <= cfg_b;
    end
  end

endmodule

>>> rtl/core/pcmag_clock.sv
// Clock chain: E and Q flops, divided channel clock, slow divider and seven-divider.
module pcmag_clock (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic                clk_level,
  input  logic                chip_rst,
  input  logic [1:0]          mode_a,
  output pcmag_pkg::clk_ctl_t ctl
);

  logic       p_clk;
  logic       p_slow;
  logic       q;
  logic       e;
  logic       d4;
  logic [7:0] slow_div;
  logic [3:0] seven;
  logic       q_next;
  logic       e_next;
  logic       d4_next;
  logic [7:0] slow_div_next;
  logic [3:0] seven_next;
  logic       slow;
  logic       slow_rise;
  logic       pre_rise;

  always_comb begin
    q_next = chip_rst ? 1'b0 : ((p_clk && !clk_level) ? e : q);
    e_next = chip_rst ? 1'b0 : ((!p_clk && clk_level) ? !q_next : e);
    ctl.e_rise  = !e && e_next;
    d4_next = chip_rst ? 1'b0 : (ctl.e_rise ? !d4 : d4);
    ctl.d4_rise = !d4 && d4_next;
    ctl.d4_fall = d4 && !d4_next;
    ctl.e  = e_next;
    ctl.q  = q_next;
    ctl.d4 = d4_next;
    slow      = slow_div[7];
    slow_rise = !p_slow && slow;
    slow_div_next = chip_rst ? '0 : (ctl.d4_rise ? slow_div + 8'd1 : slow_div);
    pre_rise  = mode_a[0] ? slow_rise : ctl.d4_rise;
    ctl.aux   = mode_a[1] ? slow : (seven == pcmag_pkg::NIBBLE_TOP);
    if (chip_rst) begin
      seven_next = '0;
    end else if (pre_rise) begin
      seven_next = (seven == pcmag_pkg::NIBBLE_TOP) ? pcmag_pkg::SEVEN_RESTART : seven + 4'd1;
    end else begin
      seven_next = seven;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_clk    <= 1'b0;
      p_slow   <= 1'b0;
      q        <= 1'b0;
      e        <= 1'b0;
      d4       <= 1'b0;
      slow_div <= '0;
      seven    <= '0;
    end else if (step) begin
      p_clk    <= clk_level;
      p_slow   <= slow;
      q        <= q_next;
      e        <= e_next;
      d4       <= d4_next;
      slow_div <= slow_div_next;
      seven    <= seven_next;
    end
  end

endmodule

>>> rtl/core/pcmag_channel.sv
// One playback channel: nibble prescaler, ROM address counter, control flags and sample latch.
module pcmag_channel (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 step,
  input  logic                 chip_rst,
  input  logic                 phase,
  input  logic                 e_rise,
  input  logic                 latch,
  input  logic                 pre_w,
  input  logic                 trig_wr,
  input  logic [7:0]           rom_byte,
  input  pcmag_pkg::chan_cfg_t cfg,
  output logic [16:0]          address,
  output logic [6:0]           sample_next
);

  logic [11:0] pcount;
  logic [16:0] acount;
  logic [6:0]  sample;
  logic        f_rpre;
  logic        f_trig;
  logic        f_crst;
  logic        f_crld;
  logic        f_stop;

  logic [11:0] pcount_next;
  logic [16:0] acount_next;
  logic        rpre_next;
  logic        trig_next;
  logic        crst_next;
  logic        crld_next;
  logic        stop_next;
  logic [3:0]  lo;
  logic [3:0]  mi;
  logic [3:0]  hi;
  logic        lc;
  logic        mc;
  logic        hin;
  logic        hc;
  logic        carry;

  assign address = acount;

  always_comb begin
    rpre_next = pre_w ? 1'b1 : (e_rise ? 1'b0 : f_rpre);
    lo    = pcount[3:0];
    mi    = pcount[7:4];
    hi    = pcount[11:8];
    lc    = phase && lo == pcmag_pkg::NIBBLE_TOP;
    mc    = lc && mi == pcmag_pkg::NIBBLE_TOP;
    hin   = cfg.mode[1] ? phase : mc;
    hc    = hin && hi == pcmag_pkg::NIBBLE_TOP;
    carry = cfg.mode[0] ? mc : hc;
    if (!e_rise) begin
      pcount_next = pcount;
    end else if (rpre_next || carry) begin
      pcount_next = cfg.reload;
    end else begin
      pcount_next = {hi + {3'b000, hin}, mi + {3'b000, lc}, lo + {3'b000, phase}};
    end

    stop_next   = latch ? rom_byte[7] : f_stop;
    sample_next = latch ? rom_byte[6:0] : sample;

    priority if (f_crst) begin
      acount_next = '0;
    end else if (!e_rise) begin
      acount_next = acount;
    end else if (f_crld) begin
      acount_next = cfg.start;
    end else if (carry && cfg.mode[1]) begin
      acount_next = {acount[16:12] + 5'd1, acount[11:8] + 4'd1,
                     acount[7:4] + 4'd1, acount[3:0] + 4'd1};
    end else if (carry) begin
      acount_next = acount + 17'd1;
    end else begin
      acount_next = acount;
    end

    priority if (chip_rst) begin
      trig_next = 1'b1;
    end else if (trig_wr) begin
      trig_next = 1'b0;
    end else if (e_rise) begin
      trig_next = 1'b1;
    end else begin
      trig_next = f_trig;
    end
    if (chip_rst) begin
      crst_next = 1'b1;
    end else if (trig_next) begin
      crst_next = f_crst || (stop_next && !cfg.loop_en);
    end else begin
      crst_next = 1'b0;
    end
    crld_next = trig_next ? (stop_next && cfg.loop_en) : 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pcount <= '0;
      acount <= '0;
      sample <= '0;
      f_rpre <= 1'b0;
      f_trig <= 1'b1;
      f_crst <= 1'b1;
      f_crld <= 1'b0;
      f_stop <= 1'b0;
    end else if (step) begin
      pcount <= pcount_next;
      acount <= acount_next;
      sample <= sample_next;
      f_rpre <= rpre_next;
      f_trig <= trig_next;
      f_crst <= crst_next;
      f_crld <= crld_next;
      f_stop <= stop_next;
    end
  end

endmodule

>>> rtl/core/two_channel_pcm_address_generator_core.sv
// Top level of the two-channel PCM address generator core.
//
// Each transfer on the item channel is one half period of the chip's master
// clock: clock level, chip reset, write select, address, data and the ROM
// byte read back for the address shown in the previous result. Each item
// gives exactly one transfer on the result channel: the multiplexed ROM
// address, the two latched channel samples, the level strobe and the E, Q
// and auxiliary clock pins.
// An item is held in an input register and processed combinationally into
// a result register; one item is taken every cycle while results are taken.
// When result_ready is low with a result waiting, the result register holds;
// an empty input register still takes one item, then item_ready drops until
// the result moves. Reset clears the valid flags of both registers, the
// clock chain, counters and the register file, and sets each channel's
// trigger and counter-reset flags. The chip reset carried in the item is
// separate and acts on the model state only.
module two_channel_pcm_address_generator_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  pcmag_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_ready,
  output pcmag_pkg::result_t result
);

  logic                 in_vld;
  pcmag_pkg::item_t     in_q;
  pcmag_pkg::result_t   res_next;
  logic                 step;
  pcmag_pkg::bus_ctl_t  bus_ctl;
  pcmag_pkg::clk_ctl_t  clk_ctl;
  pcmag_pkg::chan_cfg_t cfg_a;
  pcmag_pkg::chan_cfg_t cfg_b;
  logic [16:0]          addr_a;
  logic [16:0]          addr_b;
  logic [6:0]           smp_a;
  logic [6:0]           smp_b;

  assign step       = in_vld && (!result_valid || result_ready);
  assign item_ready = !in_vld || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (item_ready) begin
      in_vld <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      in_q <= item;
    end
  end

  pcmag_bus u_bus (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .write_strobe_n (in_q.write_strobe_n),
    .bus_address    (in_q.bus_address),
    .bus_data       (in_q.bus_data),
    .ctl            (bus_ctl),
    .cfg_a          (cfg_a),
    .cfg_b          (cfg_b)
  );

  pcmag_clock u_clock (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .clk_level (in_q.clk_level),
    .chip_rst  (in_q.reset_active),
    .mode_a    (cfg_a.mode),
    .ctl       (clk_ctl)
  );

  pcmag_channel u_chan_a (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .chip_rst    (in_q.reset_active),
    .phase       (clk_ctl.d4),
    .e_rise      (clk_ctl.e_rise),
    .latch       (clk_ctl.d4_rise),
    .pre_w       (bus_ctl.pre_a),
    .trig_wr     (bus_ctl.trig_a),
    .rom_byte    (in_q.rom_byte),
    .cfg         (cfg_a),
    .address     (addr_a),
    .sample_next (smp_a)
  );

  pcmag_channel u_chan_b (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .chip_rst    (in_q.reset_active),
    .phase       (!clk_ctl.d4),
    .e_rise      (clk_ctl.e_rise),
    .latch       (clk_ctl.d4_fall),
    .pre_w       (bus_ctl.pre_b),
    .trig_wr     (bus_ctl.trig_b),
    .rom_byte    (in_q.rom_byte),
    .cfg         (cfg_b),
    .address     (addr_b),
    .sample_next (smp_b)
  );

  always_comb begin
    res_next.rom_address    = clk_ctl.d4 ? addr_b : addr_a;
    res_next.sample_a       = smp_a;
    res_next.sample_b       = smp_b;
    res_next.level_strobe_n = bus_ctl.level_n;
    res_next.clock_e_n      = clk_ctl.e;
    res_next.clock_q_n      = clk_ctl.q;
    res_next.aux_clock_out  = clk_ctl.aux;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (step) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= res_next;
    end
  end

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !item_ready |-> (in_vld && result_valid && !result_ready))
    else $error("item_ready low without a stalled result");

  a_step_gives_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("processed item did not produce a result");

  a_chip_reset_clocks: assert property (@(posedge clk) disable iff (rst)
    (step && in_q.reset_active) |=> (!result.clock_e_n && !result.clock_q_n))
    else $error("clock pins not cleared under chip reset");

endmodule
